// File: sv/vtp_pkg.sv
// Package for the vertex transform / perspective divide block.
// Holds widths, latencies, register indexes and the matrix reset values.
`default_nettype none
package vtp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 8;
  localparam int NUM_CFG   = 8;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int MAG_W     = PROD_W;
  localparam int QW        = COORD_W;

  // Product stage plus row-sum stage.
  localparam int MAC_LAT   = 2;
  // Setup stage, one stage per quotient bit, saturation stage.
  localparam int DIV_LAT   = QW + 2;
  localparam int PIPE_LAT  = MAC_LAT + DIV_LAT;

  localparam logic [CFG_W-1:0] ONE_FX = CFG_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_COLS01 = CFG_IDX_W'(0),
    REG_ROW0_COLS23 = CFG_IDX_W'(1),
    REG_ROW1_COLS01 = CFG_IDX_W'(2),
    REG_ROW1_COLS23 = CFG_IDX_W'(3),
    REG_ROW2_COLS01 = CFG_IDX_W'(4),
    REG_ROW2_COLS23 = CFG_IDX_W'(5),
    REG_ROW3_COLS01 = CFG_IDX_W'(6),
    REG_ROW3_COLS23 = CFG_IDX_W'(7)
  } cfg_reg_e;

  // Identity matrix.
  localparam logic [NUM_CFG-1:0][CFG_W-1:0] CFG_RESET = '{
    7: ONE_FX << COORD_W,
    6: '0,
    5: ONE_FX,
    4: '0,
    3: '0,
    2: ONE_FX << COORD_W,
    1: '0,
    0: ONE_FX
  };

endpackage
`default_nettype wire

// File: sv/vtp_ifs.sv
// Valid/ready channel interfaces: vertex in, screen result out, register write.
// Depends on vtp_pkg.
`default_nettype none
interface vtp_vertex_if import vtp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic signed [COORD_W-1:0] vertex_z;
  modport source (output valid, vertex_x, vertex_y, vertex_z, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, output ready);
endinterface

interface vtp_screen_if import vtp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] screen_x;
  logic signed [COORD_W-1:0] screen_y;
  logic signed [COORD_W-1:0] screen_depth;
  logic                      divide_by_zero;
  logic                      saturated;
  modport source (output valid, screen_x, screen_y, screen_depth, divide_by_zero,
                  saturated, input ready);
  modport sink   (input valid, screen_x, screen_y, screen_depth, divide_by_zero,
                  saturated, output ready);
endinterface

interface vtp_cfg_if import vtp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/vertex_transform_perspective_divide_core.sv
// Top level of the vertex transform / perspective divide pipeline.
// Depends on vtp_pkg, vtp_ifs, vtp_row_mac and vtp_divider.
//
// Usage:
//   vertex_i  : valid/ready channel, one world-space vertex (x, y, z, Q16.16) a word.
//   screen_o  : valid/ready channel, one screen word per vertex, in order:
//               x/w, y/w, z/w truncated toward zero and clamped, plus the
//               divide_by_zero and saturated flags.
//   cfg_i     : register write channel, always ready. Index 0..7 selects the
//               packed matrix row halves; other indexes are dropped. Write only
//               while the pipe is empty.
// Pipeline: the products register at input accept, then the row-sum register,
//   the bit-per-stage divide pipeline with its setup and clamp stages, and the
//   output register.
// Throughput: one vertex per cycle while the pipe is not stalled; the divider
//   retires one quotient bit per stage, so every stage holds a different vertex.
// Reset: valid bits clear, the matrix returns to identity.
// Stall: the whole pipe holds while the output word waits and screen_o.ready
//   is low; a bubble in the output register still lets the pipe advance.
`default_nettype none
module vertex_transform_perspective_divide_core import vtp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vtp_cfg_if.sink      cfg_i,
  vtp_vertex_if.sink   vertex_i,
  vtp_screen_if.source screen_o
);

  logic [NUM_CFG-1:0][CFG_W-1:0] cfg_q;
  logic                          en;

  logic [PIPE_LAT-1:0] vld_q;
  logic [DIV_LAT-1:0]  dz_q;
  logic                w_zero;

  logic signed [SUM_W-1:0]   sum   [4];
  logic signed [COORD_W-1:0] quot  [3];
  logic                      sat   [3];

  logic                      out_valid_q;
  logic signed [COORD_W-1:0] out_x_q, out_y_q, out_z_q;
  logic                      out_dz_q, out_sat_q;

  // Advance whenever the output register is empty or being drained.
  assign en             = !out_valid_q || screen_o.ready;
  assign vertex_i.ready = en;
  assign cfg_i.ready    = 1'b1;

  // Matrix registers; out-of-range indexes drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid && (cfg_i.index <= REG_ROW3_COLS23)) begin
      cfg_q[cfg_i.index[$clog2(NUM_CFG)-1:0]] <= cfg_i.data;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    vtp_row_mac u_mac (
      .clk_i (clk_i),
      .en_i  (en),
      .c01_i (cfg_q[2*r]),
      .c23_i (cfg_q[2*r+1]),
      .x_i   (vertex_i.vertex_x),
      .y_i   (vertex_i.vertex_y),
      .z_i   (vertex_i.vertex_z),
      .sum_o (sum[r])
    );
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    vtp_divider u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (sum[c]),
      .den_i  (sum[3]),
      .quot_o (quot[c]),
      .sat_o  (sat[c])
    );
  end

  assign w_zero = (sum[3] == '0);

  // Valid bits ride alongside the data; zero-w flag waits out the divide.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[PIPE_LAT-2:0], vertex_i.valid};
      out_valid_q <= vld_q[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dz_q      <= {dz_q[DIV_LAT-2:0], w_zero};
      out_dz_q  <= dz_q[DIV_LAT-1];
      // Zero w forces zero coordinates and no saturation.
      out_x_q   <= dz_q[DIV_LAT-1] ? '0 : quot[0];
      out_y_q   <= dz_q[DIV_LAT-1] ? '0 : quot[1];
      out_z_q   <= dz_q[DIV_LAT-1] ? '0 : quot[2];
      out_sat_q <= !dz_q[DIV_LAT-1] && (sat[0] || sat[1] || sat[2]);
    end
  end

  assign screen_o.valid          = out_valid_q;
  assign screen_o.screen_x       = out_x_q;
  assign screen_o.screen_y       = out_y_q;
  assign screen_o.screen_depth   = out_z_q;
  assign screen_o.divide_by_zero = out_dz_q;
  assign screen_o.saturated      = out_sat_q;

endmodule
`default_nettype wire

// File: sv/vtp_row_mac.sv
// One matrix row times (x, y, z, 1.0): registered products, then registered sum.
// Depends on vtp_pkg.
`default_nettype none
module vtp_row_mac import vtp_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [CFG_W-1:0]          c01_i,
  input  wire logic [CFG_W-1:0]          c23_i,
  input  wire logic signed [COORD_W-1:0] x_i,
  input  wire logic signed [COORD_W-1:0] y_i,
  input  wire logic signed [COORD_W-1:0] z_i,
  output logic signed [SUM_W-1:0]        sum_o
);

  logic signed [COORD_W-1:0] c0, c1, c2, c3;
  logic signed [PROD_W-1:0]  p0_d, p1_d, p2_d, p3_d;
  logic signed [PROD_W-1:0]  p0_q, p1_q, p2_q, p3_q;
  logic signed [SUM_W-1:0]   sum_d, sum_q;

  assign c0 = $signed(c01_i[COORD_W-1:0]);
  assign c1 = $signed(c01_i[CFG_W-1:COORD_W]);
  assign c2 = $signed(c23_i[COORD_W-1:0]);
  assign c3 = $signed(c23_i[CFG_W-1:COORD_W]);

  always_comb begin
    p0_d = PROD_W'(c0) * PROD_W'(x_i);
    p1_d = PROD_W'(c1) * PROD_W'(y_i);
    p2_d = PROD_W'(c2) * PROD_W'(z_i);
    // Constant 1.0 column: scale only.
    p3_d = PROD_W'(c3) <<< FRAC_BITS;
    sum_d = SUM_W'(p0_q) + SUM_W'(p1_q) + SUM_W'(p2_q) + SUM_W'(p3_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q  <= p0_d;
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      p3_q  <= p3_d;
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule
`default_nettype wire

// File: sv/vtp_divider.sv
// Pipelined signed fixed-point divide num/den, one quotient bit per stage,
// truncating toward zero and saturating to the coordinate range. Depends on vtp_pkg.
`default_nettype none
module vtp_divider import vtp_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [SUM_W-1:0] num_i,
  input  wire logic signed [SUM_W-1:0] den_i,
  output logic signed [COORD_W-1:0]    quot_o,
  output logic                         sat_o
);

  logic [MAG_W-1:0] nmag, dmag, hi;
  logic             neg_d, ovf_d;

  logic [QW:0][MAG_W-1:0] r_q, d_q;
  logic [QW:0][QW-1:0]    lo_q, q_q;
  logic [QW:0]            neg_q, ovf_q;

  logic signed [COORD_W-1:0] quot_d, quot_q;
  logic                      sat_d, sat_q;

  // Setup: magnitudes, sign, and the top of the shifted numerator as first remainder.
  always_comb begin
    nmag  = num_i[SUM_W-1] ? MAG_W'(-num_i) : MAG_W'(num_i);
    dmag  = den_i[SUM_W-1] ? MAG_W'(-den_i) : MAG_W'(den_i);
    neg_d = num_i[SUM_W-1] ^ den_i[SUM_W-1];
    hi    = nmag >> (QW - FRAC_BITS);
    // Quotient needs more than QW bits.
    ovf_d = (hi >= dmag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= hi;
      d_q[0]   <= dmag;
      lo_q[0]  <= QW'(nmag << FRAC_BITS);
      q_q[0]   <= '0;
      neg_q[0] <= neg_d;
      ovf_q[0] <= ovf_d;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [MAG_W:0] rs, diff;
    logic           ge;
    always_comb begin
      rs   = {r_q[k], lo_q[k][QW-1]};
      diff = rs - {1'b0, d_q[k]};
      ge   = (rs >= {1'b0, d_q[k]});
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]   <= ge ? diff[MAG_W-1:0] : rs[MAG_W-1:0];
        d_q[k+1]   <= d_q[k];
        lo_q[k+1]  <= lo_q[k] << 1;
        q_q[k+1]   <= {q_q[k][QW-2:0], ge};
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  // Clamp: positive limit 2^31-1, negative limit -2^31.
  always_comb begin
    if (!neg_q[QW]) begin
      sat_d  = ovf_q[QW] || q_q[QW][QW-1];
      quot_d = sat_d ? $signed({1'b0, {(QW-1){1'b1}}}) : $signed(q_q[QW]);
    end else begin
      sat_d  = ovf_q[QW] || (q_q[QW] > {1'b1, {(QW-1){1'b0}}});
      quot_d = sat_d ? $signed({1'b1, {(QW-1){1'b0}}}) : $signed(-q_q[QW]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= quot_d;
      sat_q  <= sat_d;
    end
  end

  assign quot_o = quot_q;
  assign sat_o  = sat_q;

endmodule
`default_nettype wire
